[sv/grfa_pkg.sv]
// ----------------------------------------------------------------------------
// grfa_pkg: shared types and codes of the grid rectangle allocator
// Opcodes, result status codes, the store command bundle and sum widths.
// ----------------------------------------------------------------------------
package grfa_pkg;

    // Request opcodes
    localparam logic [2:0] OP_FIND       = 3'd0;
    localparam logic [2:0] OP_FIND_CLAIM = 3'd1;
    localparam logic [2:0] OP_CLAIM_AT   = 3'd2;
    localparam logic [2:0] OP_RELEASE_AT = 3'd3;
    localparam logic [2:0] OP_CLEAR_ALL  = 3'd4;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_OUT  = 2'd2
    } t_status;

    // Width of position plus size sums (grid index up to 15, size up to 15)
    localparam int SUM_W = 6;

    // Occupancy store write command
    typedef struct packed {
        logic wr;       // update one row under a column mask
        logic set;      // 1: mark occupied, 0: mark free
        logic clr_all;  // free every cell
    } t_store_cmd;

endpackage

[sv/grfa_store.sv]
// ----------------------------------------------------------------------------
// grfa_store: occupancy bitmap
// One row of column bits per grid row; one row read and one row update
// per cycle, plus a clear that frees every row of the grid at once.
// ----------------------------------------------------------------------------
module grfa_store #(
    parameter int GRID_ROWS = 8,
    parameter int GRID_COLS = 8,
    parameter int RW        = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  grfa_pkg::t_store_cmd i_cmd,
    input  logic [RW-1:0]        i_wr_row,
    input  logic [GRID_COLS-1:0] i_wr_mask,
    input  logic [RW-1:0]        i_rd_row,
    output logic [GRID_COLS-1:0] o_rd_data
);

    logic [GRID_COLS-1:0] r_occ [GRID_ROWS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_all) begin
            for (int i = 0; i < GRID_ROWS; i++) begin
                r_occ[i] <= '0;
            end
        end else if (i_cmd.wr) begin
            if (i_cmd.set) begin
                r_occ[i_wr_row] <= r_occ[i_wr_row] | i_wr_mask;
            end else begin
                r_occ[i_wr_row] <= r_occ[i_wr_row] & ~i_wr_mask;
            end
        end
    end

    assign o_rd_data = r_occ[i_rd_row];

endmodule

[sv/grfa_rowfit.sv]
// ----------------------------------------------------------------------------
// grfa_rowfit: per-row fit test
// For one occupancy row, flag every left column where a span of the given
// width stays inside the grid and covers only free cells.
// ----------------------------------------------------------------------------
module grfa_rowfit #(
    parameter int GRID_COLS = 8
) (
    input  logic [GRID_COLS-1:0] i_row,
    input  logic [3:0]           i_width,
    output logic [GRID_COLS-1:0] o_fit
);

    logic [GRID_COLS-1:0] span [GRID_COLS];

    always_comb begin
        for (int c = 0; c < GRID_COLS; c++) begin
            for (int k = 0; k < GRID_COLS; k++) begin
                span[c][k] = (k >= c) &&
                    (grfa_pkg::SUM_W'(k) <
                     grfa_pkg::SUM_W'(c) + grfa_pkg::SUM_W'(i_width));
            end
            o_fit[c] = (grfa_pkg::SUM_W'(c) + grfa_pkg::SUM_W'(i_width) <=
                        grfa_pkg::SUM_W'(GRID_COLS)) &&
                       ((i_row & span[c]) == '0);
        end
    end

endmodule

[sv/grid_rect_first_fit_allocator.sv]
// ----------------------------------------------------------------------------
// grid_rect_first_fit_allocator: first-fit rectangle allocator on a bitmap
// A find reads one occupancy row per cycle through a shared row fit unit and
// ANDs the fit masks of the rectangle's rows for one anchor row at a time,
// moving on to the next anchor row when the mask empties; a find-and-claim
// then writes the found rows one by one. Claim-at and release-at write their
// rows one by one; clear-all, bad sizes and unused opcodes go straight to
// the result. The block takes one request at a time and holds o_in_stall high
// while busy; a finished result waits in the output register as the next runs.
// ----------------------------------------------------------------------------
module grid_rect_first_fit_allocator #(
    parameter int GRID_ROWS = 8,
    parameter int GRID_COLS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_opcode,
    input  logic [2:0] i_anchor_row,
    input  logic [2:0] i_anchor_col,
    input  logic [3:0] i_rect_width,
    input  logic [3:0] i_rect_height,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_status,
    output logic [2:0] o_found_row,
    output logic [2:0] o_found_col
);

    localparam int RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int CW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int SW = grfa_pkg::SUM_W;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WRITE, S_EMIT} t_state;

    t_state               r_state, n_state;
    logic [2:0]           r_op, n_op;
    logic [3:0]           r_w, n_w;
    logic [3:0]           r_h, n_h;
    logic [RW-1:0]        r_anchor, n_anchor;
    logic [RW-1:0]        r_row, n_row;
    logic [3:0]           r_left, n_left;
    logic [GRID_COLS-1:0] r_acc, n_acc;
    logic [GRID_COLS-1:0] r_mask, n_mask;
    logic                 r_set, n_set;
    grfa_pkg::t_status    r_res_st, n_res_st;
    logic [RW-1:0]        r_res_row, n_res_row;
    logic [CW-1:0]        r_res_col, n_res_col;
    logic                 r_out_valid, n_out_valid;
    grfa_pkg::t_status    r_out_st, n_out_st;
    logic [2:0]           r_out_row, n_out_row;
    logic [2:0]           r_out_col, n_out_col;

    grfa_pkg::t_store_cmd st_cmd;
    logic [GRID_COLS-1:0] rd_data;
    logic [GRID_COLS-1:0] fit;
    logic [GRID_COLS-1:0] acc_n;
    logic [CW-1:0]        low_col;
    logic [GRID_COLS-1:0] in_mask;
    logic [GRID_COLS-1:0] found_mask;
    logic                 accept;
    logic                 in_inside;

    grfa_store #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS),
        .RW        (RW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (st_cmd),
        .i_wr_row  (r_row),
        .i_wr_mask (r_mask),
        .i_rd_row  (r_row),
        .o_rd_data (rd_data)
    );

    grfa_rowfit #(
        .GRID_COLS (GRID_COLS)
    ) u_rowfit (
        .i_row   (rd_data),
        .i_width (r_w),
        .o_fit   (fit)
    );

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign acc_n      = r_acc & fit;

    assign in_inside = (i_rect_width != '0) && (i_rect_height != '0) &&
                       (SW'(i_anchor_row) + SW'(i_rect_height) <= SW'(GRID_ROWS)) &&
                       (SW'(i_anchor_col) + SW'(i_rect_width) <= SW'(GRID_COLS));

    // Lowest fitting column of the finished anchor row
    always_comb begin
        low_col = '0;
        for (int c = GRID_COLS - 1; c >= 0; c--) begin
            if (acc_n[c]) begin
                low_col = CW'(c);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < GRID_COLS; k++) begin
            in_mask[k] = (SW'(k) >= SW'(i_anchor_col)) &&
                         (SW'(k) < SW'(i_anchor_col) + SW'(i_rect_width));
            found_mask[k] = (SW'(k) >= SW'(low_col)) &&
                            (SW'(k) < SW'(low_col) + SW'(r_w));
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_w         = r_w;
        n_h         = r_h;
        n_anchor    = r_anchor;
        n_row       = r_row;
        n_left      = r_left;
        n_acc       = r_acc;
        n_mask      = r_mask;
        n_set       = r_set;
        n_res_st    = r_res_st;
        n_res_row   = r_res_row;
        n_res_col   = r_res_col;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_st    = r_out_st;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        st_cmd      = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op      = i_opcode;
                    n_w       = i_rect_width;
                    n_h       = i_rect_height;
                    n_res_st  = grfa_pkg::ST_OK;
                    n_res_row = '0;
                    n_res_col = '0;
                    n_state   = S_EMIT;
                    if (i_opcode == grfa_pkg::OP_FIND ||
                        i_opcode == grfa_pkg::OP_FIND_CLAIM) begin
                        if (i_rect_width == '0 || i_rect_height == '0) begin
                            n_res_st = grfa_pkg::ST_OUT;
                        end else if (SW'(i_rect_height) > SW'(GRID_ROWS) ||
                                     SW'(i_rect_width) > SW'(GRID_COLS)) begin
                            n_res_st = grfa_pkg::ST_NONE;
                        end else begin
                            n_anchor = '0;
                            n_row    = '0;
                            n_left   = i_rect_height - 4'd1;
                            n_acc    = '1;
                            n_state  = S_SCAN;
                        end
                    end else if (i_opcode == grfa_pkg::OP_CLAIM_AT ||
                                 i_opcode == grfa_pkg::OP_RELEASE_AT) begin
                        if (in_inside) begin
                            n_row   = RW'(i_anchor_row);
                            n_left  = i_rect_height - 4'd1;
                            n_mask  = in_mask;
                            n_set   = (i_opcode == grfa_pkg::OP_CLAIM_AT);
                            n_state = S_WRITE;
                        end else begin
                            n_res_st = grfa_pkg::ST_OUT;
                        end
                    end else if (i_opcode == grfa_pkg::OP_CLEAR_ALL) begin
                        st_cmd.clr_all = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (acc_n == '0) begin
                    // Anchor row fails: advance or give up at the bottom edge
                    if (SW'(r_anchor) + SW'(r_h) >= SW'(GRID_ROWS)) begin
                        n_res_st = grfa_pkg::ST_NONE;
                        n_state  = S_EMIT;
                    end else begin
                        n_anchor = r_anchor + RW'(1);
                        n_row    = r_anchor + RW'(1);
                        n_left   = r_h - 4'd1;
                        n_acc    = '1;
                    end
                end else if (r_left == '0) begin
                    n_res_row = r_anchor;
                    n_res_col = low_col;
                    if (r_op == grfa_pkg::OP_FIND_CLAIM) begin
                        n_row   = r_anchor;
                        n_left  = r_h - 4'd1;
                        n_mask  = found_mask;
                        n_set   = 1'b1;
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_EMIT;
                    end
                end else begin
                    n_acc  = acc_n;
                    n_row  = r_row + RW'(1);
                    n_left = r_left - 4'd1;
                end
            end
            S_WRITE: begin
                st_cmd.wr  = 1'b1;
                st_cmd.set = r_set;
                if (r_left == '0) begin
                    n_state = S_EMIT;
                end else begin
                    n_row  = r_row + RW'(1);
                    n_left = r_left - 4'd1;
                end
            end
            S_EMIT: begin
                // Hold the result until the output register frees up
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_st    = r_res_st;
                    n_out_row   = 3'(r_res_row);
                    n_out_col   = 3'(r_res_col);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_op      <= n_op;
        r_w       <= n_w;
        r_h       <= n_h;
        r_anchor  <= n_anchor;
        r_row     <= n_row;
        r_left    <= n_left;
        r_acc     <= n_acc;
        r_mask    <= n_mask;
        r_set     <= n_set;
        r_res_st  <= n_res_st;
        r_res_row <= n_res_row;
        r_res_col <= n_res_col;
        r_out_st  <= n_out_st;
        r_out_row <= n_out_row;
        r_out_col <= n_out_col;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_st;
    assign o_found_row = r_out_row;
    assign o_found_col = r_out_col;

    a_load_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_EMIT)
        else $error("result loaded outside emit state");

    a_write_in_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_cmd.wr |-> r_state == S_WRITE && r_mask != '0)
        else $error("store write outside write state or with empty mask");

    a_scan_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> SW'(r_row) < SW'(GRID_ROWS) &&
                              SW'(r_anchor) + SW'(r_h) <= SW'(GRID_ROWS))
        else $error("scan left the grid");

    a_miss_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != grfa_pkg::ST_OK |->
            o_found_row == '0 && o_found_col == '0)
        else $error("failed request reports a position");

endmodule

[tb/tb_grid_rect_first_fit_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_rect_first_fit_allocator: self-checking bench of the rectangle allocator
// Keeps its own copy of the occupancy grid and computes the expected result
// of every accepted request. A queue-fed driver and a clocked monitor run with
// random gaps and output stalls. One stretch of requests runs with neither.
// ----------------------------------------------------------------------------
module tb_grid_rect_first_fit_allocator;

    localparam int GRID_ROWS = 8;
    localparam int GRID_COLS = 8;
    localparam int RANDOM_REQUESTS = 550;
    localparam int DRAIN_CYCLES = 100;
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] anchor_row;
        logic [2:0] anchor_col;
        logic [3:0] width;
        logic [3:0] height;
    } t_alloc_req;

    typedef struct packed {
        grfa_pkg::t_status status;
        logic [2:0]        row;
        logic [2:0]        col;
    } t_alloc_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [2:0] i_opcode = '0;
    logic [2:0] i_anchor_row = '0;
    logic [2:0] i_anchor_col = '0;
    logic [3:0] i_rect_width = '0;
    logic [3:0] i_rect_height = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [1:0] o_status;
    logic [2:0] o_found_row;
    logic [2:0] o_found_col;

    t_alloc_req            req_queue[$];
    t_alloc_result         expected_results[$];
    logic [GRID_COLS-1:0]  occ_grid[GRID_ROWS] = '{default: '0};
    int                    sent_count = 0;
    int                    err_count = 0;
    logic                  no_gaps;

    grid_rect_first_fit_allocator #(
        .GRID_ROWS(GRID_ROWS),
        .GRID_COLS(GRID_COLS)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_opcode(i_opcode),
        .i_anchor_row(i_anchor_row),
        .i_anchor_col(i_anchor_col),
        .i_rect_width(i_rect_width),
        .i_rect_height(i_rect_height),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_status(o_status),
        .o_found_row(o_found_row),
        .o_found_col(o_found_col)
    );

    always #5 i_clk = ~i_clk;

    // no idling on either side for this stretch of requests
    assign no_gaps = (sent_count >= 200) && (sent_count < 320);

    function automatic logic [GRID_COLS-1:0] span_mask(int c, int w);
        logic [GRID_COLS-1:0] m;
        for (int j = 0; j < GRID_COLS; j++) begin
            m[j] = (j >= c) && (j < c + w);
        end
        return m;
    endfunction

    function automatic bit rect_fits(int r, int c, int w, int h);
        return (w != 0) && (h != 0) && (r + h <= GRID_ROWS) && (c + w <= GRID_COLS);
    endfunction

    function automatic void write_rect(int r, int c, int w, int h, bit occupied);
        logic [GRID_COLS-1:0] m;
        m = span_mask(c, w);
        for (int i = r; i < r + h; i++) begin
            if (occupied) begin
                occ_grid[i] = occ_grid[i] | m;
            end else begin
                occ_grid[i] = occ_grid[i] & ~m;
            end
        end
    endfunction

    // Advance the grid copy by one request and return its result
    function automatic t_alloc_result apply_request(t_alloc_req req);
        t_alloc_result        res;
        bit                   hit;
        bit                   clear;
        int                   w;
        int                   h;
        logic [GRID_COLS-1:0] m;
        res = '{status: grfa_pkg::ST_OK, row: '0, col: '0};
        hit = 1'b0;
        w = req.width;
        h = req.height;
        case (req.op)
            grfa_pkg::OP_FIND, grfa_pkg::OP_FIND_CLAIM: begin
                if (w == 0 || h == 0) begin
                    res.status = grfa_pkg::ST_OUT;
                end else begin
                    for (int r = 0; r < GRID_ROWS; r++) begin
                        for (int c = 0; c < GRID_COLS; c++) begin
                            if (!hit && rect_fits(r, c, w, h)) begin
                                m = span_mask(c, w);
                                clear = 1'b1;
                                for (int i = r; i < r + h; i++) begin
                                    if ((occ_grid[i] & m) != '0) clear = 1'b0;
                                end
                                if (clear) begin
                                    hit = 1'b1;
                                    res.row = 3'(r);
                                    res.col = 3'(c);
                                end
                            end
                        end
                    end
                    if (!hit) begin
                        res.status = grfa_pkg::ST_NONE;
                    end else if (req.op == grfa_pkg::OP_FIND_CLAIM) begin
                        write_rect(res.row, res.col, w, h, 1'b1);
                    end
                end
            end
            grfa_pkg::OP_CLAIM_AT, grfa_pkg::OP_RELEASE_AT: begin
                if (rect_fits(req.anchor_row, req.anchor_col, w, h)) begin
                    write_rect(req.anchor_row, req.anchor_col, w, h,
                               req.op == grfa_pkg::OP_CLAIM_AT);
                end else begin
                    res.status = grfa_pkg::ST_OUT;
                end
            end
            grfa_pkg::OP_CLEAR_ALL: begin
                occ_grid = '{default: '0};
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic queue_request(logic [2:0] op, int ar, int ac, int w, int h);
        t_alloc_req req;
        req = '{op: op, anchor_row: 3'(ar), anchor_col: 3'(ac),
                width: 4'(w), height: 4'(h)};
        req_queue.insert(req_queue.size(), req);
    endtask

    function automatic int random_size();
        int pick;
        pick = $urandom_range(9);
        if (pick < 6) return $urandom_range(4, 1);
        if (pick < 8) return $urandom_range(8, 5);
        if (pick == 8) return 0;
        return $urandom_range(15, 9);
    endfunction

    // Driver: hold the payload while stalled, advance on acceptance
    always @(posedge i_clk) begin : request_driver
        t_alloc_req next_req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (req_queue.size() > 0 && (no_gaps || $urandom_range(99) >= 32)) begin
                next_req = req_queue.pop_front();
                i_opcode <= next_req.op;
                i_anchor_row <= next_req.anchor_row;
                i_anchor_col <= next_req.anchor_col;
                i_rect_width <= next_req.width;
                i_rect_height <= next_req.height;
                i_in_valid <= 1'b1;
                sent_count <= sent_count + 1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= !no_gaps && ($urandom_range(99) < 32);
        end
    end

    always @(posedge i_clk) begin : result_predictor
        t_alloc_result pred_res;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            pred_res = apply_request('{op: i_opcode,
                anchor_row: i_anchor_row, anchor_col: i_anchor_col,
                width: i_rect_width, height: i_rect_height});
            expected_results.insert(expected_results.size(), pred_res);
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_alloc_result exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: status %0d row %0d col %0d",
                       o_status, o_found_row, o_found_col);
                err_count++;
            end else begin
                exp_res = expected_results.pop_front();
                if (o_status !== exp_res.status) begin
                    $error("status mismatch: expected %0d, actual %0d", exp_res.status, o_status);
                    err_count++;
                end
                if (o_found_row !== exp_res.row) begin
                    $error("found_row mismatch: expected %0d, actual %0d",
                           exp_res.row, o_found_row);
                    err_count++;
                end
                if (o_found_col !== exp_res.col) begin
                    $error("found_col mismatch: expected %0d, actual %0d",
                           exp_res.col, o_found_col);
                    err_count++;
                end
            end
        end
    end

    initial begin : stimulus
        int pick;
        int w;
        int h;
        logic [2:0] op;

        // directed: empty grid, full grid, bounds and odd opcodes
        queue_request(grfa_pkg::OP_FIND, 5, 2, 1, 1);
        queue_request(grfa_pkg::OP_FIND, 0, 0, 8, 8);
        queue_request(grfa_pkg::OP_FIND_CLAIM, 7, 7, 8, 8);
        queue_request(grfa_pkg::OP_FIND, 0, 0, 1, 1);
        queue_request(grfa_pkg::OP_RELEASE_AT, 0, 0, 8, 8);
        queue_request(grfa_pkg::OP_FIND, 0, 0, 0, 3);
        queue_request(grfa_pkg::OP_FIND_CLAIM, 0, 0, 2, 0);
        queue_request(grfa_pkg::OP_FIND, 0, 0, 9, 1);
        queue_request(grfa_pkg::OP_FIND_CLAIM, 0, 0, 15, 15);
        queue_request(grfa_pkg::OP_CLAIM_AT, 7, 7, 1, 1);
        queue_request(grfa_pkg::OP_CLAIM_AT, 7, 7, 2, 1);
        queue_request(grfa_pkg::OP_RELEASE_AT, 7, 7, 1, 2);
        queue_request(grfa_pkg::OP_CLAIM_AT, 3, 3, 0, 1);
        queue_request(grfa_pkg::OP_RELEASE_AT, 0, 0, 0, 15);
        queue_request(grfa_pkg::OP_CLAIM_AT, 2, 3, 3, 2);
        queue_request(grfa_pkg::OP_CLAIM_AT, 2, 3, 3, 2);
        queue_request(grfa_pkg::OP_FIND_CLAIM, 0, 0, 4, 3);
        queue_request(grfa_pkg::OP_RELEASE_AT, 6, 0, 1, 1);
        queue_request(grfa_pkg::OP_FIND, 0, 0, 8, 1);
        queue_request(grfa_pkg::OP_CLEAR_ALL, 7, 7, 15, 15);
        queue_request(OP_UNUSED_FIRST, 7, 0, 8, 8);
        queue_request(3'(OP_UNUSED_FIRST + 3'd1), 0, 7, 0, 0);
        queue_request(OP_UNUSED_LAST, 7, 7, 15, 15);
        queue_request(grfa_pkg::OP_CLAIM_AT, 0, 0, 8, 8);
        queue_request(grfa_pkg::OP_CLEAR_ALL, 0, 0, 1, 1);

        // random: mostly well-formed traffic with small rectangles
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            pick = $urandom_range(99);
            w = random_size();
            h = random_size();
            if (pick < 30) begin
                op = grfa_pkg::OP_FIND_CLAIM;
            end else if (pick < 50) begin
                op = grfa_pkg::OP_FIND;
            end else if (pick < 65) begin
                op = grfa_pkg::OP_CLAIM_AT;
            end else if (pick < 88) begin
                op = grfa_pkg::OP_RELEASE_AT;
            end else if (pick < 93) begin
                op = grfa_pkg::OP_CLEAR_ALL;
            end else if (pick < 96) begin
                op = 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
            end else begin
                op = 3'($urandom_range(7));
                w = $urandom_range(15);
                h = $urandom_range(15);
            end
            queue_request(op, $urandom_range(7), $urandom_range(7), w, h);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_queue.size() > 0 || i_in_valid || expected_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_results.size() > 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $error("timeout: %0d results still expected", expected_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
